FILE: hw/rtl/k_weighted_loudness_windows_top_macros.svh
// assertion macros for the loudness meter checker
`ifndef K_WEIGHTED_LOUDNESS_WINDOWS_TOP_MACROS_SVH
`define K_WEIGHTED_LOUDNESS_WINDOWS_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define KWL_ASSERT(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cond) else $error(msg);

// condition on one edge implies another on the next edge
`define KWL_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: hw/rtl/kwl_pkg.sv
`timescale 1ns / 1ps
package kwl_pkg;
  localparam int CoefWidth = 32;
  localparam int LenWidth = 15;
  localparam int YWidth = 25;
  localparam int PowWidth = 50;
  localparam int EnergyWidth = 64;
  localparam int IdxWidth = 3;

  // register indexes
  typedef enum logic [IdxWidth-1:0] {
    REG_SHELF_B0 = 3'd0, REG_SHELF_B1 = 3'd1, REG_SHELF_B2 = 3'd2,
    REG_SHELF_A1 = 3'd3, REG_SHELF_A2 = 3'd4, REG_HP_A1 = 3'd5,
    REG_HP_A2 = 3'd6, REG_SUBBLOCK_LEN = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [CoefWidth-1:0] b0, b1, b2, a1, a2, ha1, ha2;
    logic [LenWidth-1:0] len;
  } coef_t;
endpackage

FILE: hw/rtl/kwl_ram.sv
`timescale 1ns / 1ps
module kwl_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/k_weighted_loudness_windows_top.sv
`timescale 1ns / 1ps
// channel   | dir | contents
// s_axis    | in  | tdata: sample_left, sample_right
// m_axis    | out | tdata: momentary_power, short_term_power; tuser: mvalid, svalid
// cfg       | in  | we, index, wdata
// A frame passes through accept, five products per filter section on one shared
// 32x32 multiplier, and an energy update. A subblock end adds a 64-bit divide per
// channel, a ring update, the window division and an output state. After rst a
// clearing pass zeroes the ring before the first frame is taken. A result waits in an
// output register; the next frame is accepted while it is held.
module k_weighted_loudness_windows_top #(
  parameter int NUM_CHANNELS = 2,
  parameter int SHORT_TERM_BLOCKS = 30,
  parameter int MOMENTARY_BLOCKS = 4,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample_left [SW-1:0], sample_right [2SW-1:SW], zero pad
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // momentary_power [49:0], short_term_power [99:50], zero pad
  output logic [103:0] m_axis_tdata,
  // momentary_valid [0], short_term_valid [1]
  output logic [1:0] m_axis_tuser,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_wdata
);
  import kwl_pkg::*;
  localparam int RingAw = $clog2(SHORT_TERM_BLOCKS);
  localparam int SumW = PowWidth + 7;
  localparam int RemW = 7;
  localparam int QDigits = (SumW + 3) / 4;
  localparam int DivW = 4 * QDigits;

  typedef enum logic [10:0] {
    S_CLR = 11'd1, S_IDLE = 11'd2, S_MUL = 11'd4, S_ACC = 11'd8, S_ENG = 11'd16,
    S_DIV = 11'd32, S_RD = 11'd64, S_WR = 11'd128, S_MOM = 11'd256,
    S_QUO = 11'd512, S_OUT = 11'd1024
  } state_t;
  state_t state;

  coef_t coef;
  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0 <= 32'sd412081942;  coef.b1 <= -32'sd722546695;
      coef.b2 <= 32'sd321691118;  coef.a1 <= -32'sd453832899;
      coef.a2 <= 32'sd196623811;  coef.ha1 <= -32'sd534199297;
      coef.ha2 <= 32'sd265770496; coef.len <= 15'd4800;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SHELF_B0: coef.b0 <= cfg_wdata;
        REG_SHELF_B1: coef.b1 <= cfg_wdata;
        REG_SHELF_B2: coef.b2 <= cfg_wdata;
        REG_SHELF_A1: coef.a1 <= cfg_wdata;
        REG_SHELF_A2: coef.a2 <= cfg_wdata;
        REG_HP_A1: coef.ha1 <= cfg_wdata;
        REG_HP_A2: coef.ha2 <= cfg_wdata;
        REG_SUBBLOCK_LEN: coef.len <= cfg_wdata[LenWidth-1:0];
        default: ;
      endcase
    end
  end

  // filter history: x1,x2,y1,y2 for shelf and high pass per channel
  logic signed [YWidth-1:0] hist [2][2][4];
  logic [EnergyWidth-1:0] energy [2];
  logic signed [SAMPLE_WIDTH-1:0] samp [2];
  logic ch, stage;
  logic [2:0] term;
  logic signed [63:0] prod, acc;
  logic signed [31:0] ma, mb;
  logic signed [YWidth-1:0] xin, yout;
  logic signed [63:0] accf, yfl;
  logic [LenWidth-1:0] fcount, len_eff;

  assign len_eff = (coef.len == '0) ? LenWidth'(1) : coef.len;

  function automatic logic signed [YWidth-1:0] align(input logic signed [SAMPLE_WIDTH-1:0] s);
    logic signed [63:0] w;
    w = 64'(s);
    if (SAMPLE_WIDTH > 24) w = w >>> (SAMPLE_WIDTH - 24);
    else w = w <<< (24 - SAMPLE_WIDTH);
    return YWidth'(w);
  endfunction

  // multiplier operand select
  always_comb begin
    xin = stage ? hist[ch][0][2] : align(samp[ch]);
    ma = '0; mb = '0;
    unique case (term)
      3'd0: begin ma = stage ? 32'sh1000_0000 : coef.b0; mb = 32'(xin); end
      3'd1: begin ma = stage ? -32'sh2000_0000 : coef.b1; mb = 32'(hist[ch][stage][0]); end
      3'd2: begin ma = stage ? 32'sh1000_0000 : coef.b2; mb = 32'(hist[ch][stage][1]); end
      3'd3: begin ma = stage ? coef.ha1 : coef.a1; mb = -32'(hist[ch][stage][2]); end
      default: begin ma = stage ? coef.ha2 : coef.a2; mb = -32'(hist[ch][stage][3]); end
    endcase
    accf = acc + prod;
    yfl = accf >>> 28;
    if (yfl > 64'sd16777215) yout = 25'sd16777215;
    else if (yfl < -64'sd16777216) yout = -25'sd16777216;
    else yout = YWidth'(yfl);
  end

  // divider and ring
  logic [EnergyWidth-1:0] rem, quo;
  logic [6:0] dbit;
  logic [PowWidth-1:0] z, rd;
  logic [SumW-1:0] wsum, msum;
  logic [RingAw-1:0] widx, ridx, ram_wa, ram_ra;
  logic [RingAw:0] fill;
  logic [3:0] mcnt;
  logic ram_we;
  logic [PowWidth-1:0] ram_wd;
  logic signed [EnergyWidth:0] trial;

  // window means: one radix-16 digit per cycle against constant multiples
  logic [DivW-1:0] mq, sq;
  logic [RemW-1:0] mr, sr;
  logic [RemW+3:0] mstep, sstep;
  logic [4:0] qcnt;

  function automatic logic [RemW+3:0] digit_step(input logic [RemW+3:0] t,
                                                 input logic [RemW+3:0] d);
    logic [3:0] q;
    q = '0;
    for (int j = 1; j < 16; j++)
      if (t >= (RemW+4)'(j) * d) q = 4'(j);
    return {q, RemW'(t - (RemW+4)'(q) * d)};
  endfunction

  assign mstep = digit_step({mr, mq[DivW-1 -: 4]}, (RemW+4)'(MOMENTARY_BLOCKS));
  assign sstep = digit_step({sr, sq[DivW-1 -: 4]}, (RemW+4)'(SHORT_TERM_BLOCKS));

  kwl_ram #(.Width(PowWidth), .Depth(SHORT_TERM_BLOCKS)) u_ring (
    .clk, .we(ram_we), .waddr(ram_wa), .wdata(ram_wd), .raddr(ram_ra), .rdata(rd)
  );

  assign trial = {rem[EnergyWidth-2:0], quo[EnergyWidth-1]} - (EnergyWidth+1)'(len_eff);
  assign s_axis_tready = (state == S_IDLE);

  function automatic logic [RingAw-1:0] dec(input logic [RingAw-1:0] i);
    return (i == '0) ? RingAw'(SHORT_TERM_BLOCKS - 1) : i - 1'b1;
  endfunction

  assign ram_ra = (state == S_MOM || state == S_WR) ? ridx : widx;

  always_comb begin
    ram_we = 1'b0; ram_wa = widx; ram_wd = z;
    if (state == S_CLR) begin ram_we = 1'b1; ram_wd = '0; end
    else if (state == S_WR) ram_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; widx <= '0; fill <= '0; wsum <= '0; fcount <= '0;
      m_axis_tvalid <= 1'b0; energy[0] <= '0; energy[1] <= '0;
      for (int c = 0; c < 2; c++)
        for (int s = 0; s < 2; s++)
          for (int k = 0; k < 4; k++) hist[c][s][k] <= '0;
    end else begin
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      prod <= 64'(ma) * 64'(mb);
      unique case (state)
        S_CLR: begin
          widx <= (widx == RingAw'(SHORT_TERM_BLOCKS - 1)) ? '0 : widx + 1'b1;
          if (widx == RingAw'(SHORT_TERM_BLOCKS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid) begin
          samp[0] <= s_axis_tdata[SAMPLE_WIDTH-1:0];
          samp[1] <= s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
          ch <= 1'b0; stage <= 1'b0; term <= '0; acc <= '0; state <= S_MUL;
        end
        S_MUL: begin term <= term + 1'b1; state <= S_ACC; end
        S_ACC: begin
          if (term == 3'd5) begin
            hist[ch][stage][1] <= hist[ch][stage][0];
            hist[ch][stage][0] <= xin;
            hist[ch][stage][3] <= hist[ch][stage][2];
            hist[ch][stage][2] <= yout;
            acc <= '0; term <= '0;
            if (stage) begin
              energy[ch] <= energy[ch] + EnergyWidth'(64'(yout) * 64'(yout));
              if (ch == 1'b1 || NUM_CHANNELS == 1) state <= S_ENG;
              else begin ch <= 1'b1; stage <= 1'b0; state <= S_MUL; end
            end else begin stage <= 1'b1; state <= S_MUL; end
          end else begin
            acc <= accf; term <= term + 1'b1;
          end
        end
        S_ENG: begin
          if (fcount + 1'b1 >= len_eff) begin
            fcount <= '0; ch <= 1'b0; z <= '0;
            rem <= '0; quo <= energy[0]; dbit <= '0; state <= S_DIV;
          end else begin
            fcount <= fcount + 1'b1; state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (dbit == 7'd63) begin
            z <= z + PowWidth'(trial[EnergyWidth] ? {quo[EnergyWidth-2:0], 1'b0}
                                                  : {quo[EnergyWidth-2:0], 1'b1});
            energy[ch] <= '0;
            if (ch == 1'b1 || NUM_CHANNELS == 1) state <= S_RD;
            else begin ch <= 1'b1; rem <= '0; quo <= energy[1]; dbit <= '0; end
          end else begin
            if (!trial[EnergyWidth]) begin
              rem <= trial[EnergyWidth-1:0]; quo <= {quo[EnergyWidth-2:0], 1'b1};
            end else begin
              rem <= {rem[EnergyWidth-2:0], quo[EnergyWidth-1]};
              quo <= {quo[EnergyWidth-2:0], 1'b0};
            end
            dbit <= dbit + 1'b1;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          wsum <= wsum - SumW'(rd) + SumW'(z);
          widx <= (widx == RingAw'(SHORT_TERM_BLOCKS - 1)) ? '0 : widx + 1'b1;
          if (fill < (RingAw+1)'(SHORT_TERM_BLOCKS)) fill <= fill + 1'b1;
          ridx <= dec(dec(widx == RingAw'(SHORT_TERM_BLOCKS - 1) ? '0 : widx + 1'b1));
          msum <= SumW'(z); mcnt <= 4'd1; state <= S_MOM;
        end
        // read data arrives in the cycle after its address
        S_MOM: begin
          if (mcnt != 4'd1) msum <= msum + SumW'(rd);
          if (mcnt == 4'(MOMENTARY_BLOCKS)) begin
            qcnt <= '0; state <= S_QUO;
          end else begin
            ridx <= dec(ridx); mcnt <= mcnt + 1'b1;
          end
        end
        // load both window sums, then one quotient digit per cycle
        S_QUO: begin
          qcnt <= qcnt + 1'b1;
          if (qcnt == '0) begin
            mq <= DivW'(msum); sq <= DivW'(wsum); mr <= '0; sr <= '0;
          end else begin
            mq <= {mq[DivW-5:0], mstep[RemW+3:RemW]}; mr <= mstep[RemW-1:0];
            sq <= {sq[DivW-5:0], sstep[RemW+3:RemW]}; sr <= sstep[RemW-1:0];
            if (qcnt == 5'(QDigits)) state <= S_OUT;
          end
        end
        S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tuser[0] <= fill >= (RingAw+1)'(MOMENTARY_BLOCKS);
          m_axis_tuser[1] <= fill >= (RingAw+1)'(SHORT_TERM_BLOCKS);
          m_axis_tdata[49:0] <= (fill >= (RingAw+1)'(MOMENTARY_BLOCKS))
              ? mq[PowWidth-1:0] : '0;
          m_axis_tdata[99:50] <= (fill >= (RingAw+1)'(SHORT_TERM_BLOCKS))
              ? sq[PowWidth-1:0] : '0;
          m_axis_tdata[103:100] <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/kwl_checker.sv
`timescale 1ns / 1ps
`include "k_weighted_loudness_windows_top_macros.svh"
module kwl_checker (
  input logic clk, rst, s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);
  `KWL_ASSERT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "dropped")
  `KWL_ASSERT(a_sv, clk, rst, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0], "valids")
  `KWL_ASSERT(a_mz, clk, rst, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[49:0] == 0, "mom")
  `KWL_ASSERT(a_sz, clk, rst, m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[99:50] == 0, "st")
  `KWL_ASSERT_NEXT(a_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy")
endmodule

bind k_weighted_loudness_windows_top kwl_checker u_kwl_checker (.*);
